// ----- rtl/int8_dot_product_engine_assert.svh -----
// Assertion macros shared by the dot-product engine RTL.
`ifndef INT8_DOT_PRODUCT_ENGINE_ASSERT_SVH
`define INT8_DOT_PRODUCT_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define I8DP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define I8DP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/i8dp_pkg.sv -----
// Constants, types and register map of the int8 dot-product engine.
package i8dp_pkg;

    localparam int LANES         = 16;
    localparam int ACT_BASE_WORD = 16;
    localparam int WGT_BASE_WORD = 32;

    localparam int BUF_WORDS = (LANES + 3) / 4;
    localparam int BUF_AW    = (BUF_WORDS > 1) ? $clog2(BUF_WORDS) : 1;
    // Signed accumulator: |sum| <= LANES * 128 * 128.
    localparam int ACC_W     = $clog2(LANES * 16384 + 1) + 1;

    localparam int ADDR_W = 6;
    localparam int DATA_W = 32;

    localparam logic [ADDR_W-1:0] ADDR_CONTROL = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] ADDR_COMMAND = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] ADDR_STATUS  = ADDR_W'(2);
    localparam logic [ADDR_W-1:0] ADDR_RESULT  = ADDR_W'(3);

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam int CTRL_ENABLE_BIT = 0;
    localparam int CTRL_CLEAR_BIT  = 1;

    typedef struct packed {
        logic              clear;
        logic              en;
        logic [BUF_AW-1:0] word_idx;
    } t_mac_ctrl;

endpackage

// ----- rtl/i8dp_ram.sv -----
// Simple dual-port synchronous RAM with registered read.
module i8dp_ram #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/i8dp_mac.sv -----
// Four-lane signed int8 multiply-accumulate, one buffer word per cycle while enabled.
module i8dp_mac import i8dp_pkg::*; (
    input  logic                    i_clk,
    input  t_mac_ctrl               i_ctrl,
    input  logic [DATA_W-1:0]       i_act,
    input  logic [DATA_W-1:0]       i_wgt,
    output logic signed [ACC_W-1:0] o_acc
);
    logic signed [ACC_W-1:0] r_acc;
    logic signed [17:0]      word_sum;

    always_comb begin
        logic signed [7:0]  a;
        logic signed [7:0]  w;
        logic signed [15:0] p;
        word_sum = '0;
        for (int k = 0; k < 4; k++) begin
            a = i_act[k*8 +: 8];
            w = i_wgt[k*8 +: 8];
            p = a * w;
            // lanes past LANES in a partial last word drop out
            if ((int'(i_ctrl.word_idx) * 4 + k) < LANES) begin
                word_sum = word_sum + 18'(p);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (i_ctrl.en) begin
            r_acc <= r_acc + ACC_W'(word_sum);
        end
    end

    assign o_acc = r_acc;
endmodule

// ----- rtl/int8_dot_product_engine.sv -----
// Top level of the register-mapped int8 dot-product engine.
//
// Usage: each slave-side transaction is one word bus access; tuser[0] is the
// access kind (0 read, 1 write), tdata carries word_addr [5:0] and
// write_data [37:6]. Every access returns exactly one master-side
// transaction whose tdata is the read word (0 for writes and unmapped reads).
// Map: 0 control (bit 0 enable, writing bit 1 clears result-valid),
// 1 command (a write while enabled runs the dot product), 2 status (bit 0
// result-valid), 3 result, then activation and weight buffers at their bases.
// Buffers live in two one-port-read RAMs; the dot product sweeps both RAMs
// one word a cycle through a four-lane MAC.
// Path from accept to result valid: register accesses and writes pass
// through S_RESP, buffer reads through S_RDBUF and S_RESP, and commands
// through the S_MAC word sweep, S_MACEND, S_FIN and S_RESP. One access is
// in flight at a time; the next is accepted once the last has left S_RESP.
// Reset (i_rst_n low, synchronous) clears enable, result-valid, the result
// and the output valid; buffer contents are undefined until written.
// A stalled receiver holds the finished transaction in the output register;
// the next access is still accepted and waits for the output slot to free.
`include "int8_dot_product_engine_assert.svh"
module int8_dot_product_engine import i8dp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // word_addr[5:0], write_data[37:6], zero pad
    input  logic [0:0]  i_s_axis_tuser,   // op[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // read_data[31:0]
);
    typedef enum logic [2:0] {
        S_IDLE, S_RDBUF, S_MAC, S_MACEND, S_FIN, S_RESP
    } t_state;

    t_state            r_state;
    logic              r_enabled;
    logic              r_result_valid;
    logic [DATA_W-1:0] r_dot_result;
    logic [BUF_AW-1:0] r_cnt;
    logic              r_rd_vld;
    logic [BUF_AW-1:0] r_rd_idx;
    logic              r_sel_act;
    logic [DATA_W-1:0] r_resp_data;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;

    // incoming transaction fields
    logic              in_op;
    logic [ADDR_W-1:0] in_addr;
    logic [DATA_W-1:0] in_wdata;
    logic              in_accept;

    assign in_op     = i_s_axis_tuser[0];
    assign in_addr   = i_s_axis_tdata[ADDR_W-1:0];
    assign in_wdata  = i_s_axis_tdata[ADDR_W +: DATA_W];
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;

    // buffer decode; activation buffer owns overlapping addresses
    logic [ADDR_W:0]   act_off;
    logic [ADDR_W:0]   wgt_off;
    logic              act_hit;
    logic              wgt_hit;

    assign act_off = {1'b0, in_addr} - (ADDR_W + 1)'(ACT_BASE_WORD);
    assign wgt_off = {1'b0, in_addr} - (ADDR_W + 1)'(WGT_BASE_WORD);
    assign act_hit = !act_off[ADDR_W] && (act_off < (ADDR_W + 1)'(BUF_WORDS));
    assign wgt_hit = !wgt_off[ADDR_W] && (wgt_off < (ADDR_W + 1)'(BUF_WORDS));

    logic              is_reg_addr;
    assign is_reg_addr = (in_addr == ADDR_CONTROL) || (in_addr == ADDR_COMMAND) ||
                         (in_addr == ADDR_STATUS)  || (in_addr == ADDR_RESULT);

    // RAM ports: writes only at accept; reads at accept or during the sweep.
    // One access at a time, so read and write never target an entry together.
    logic              act_we, wgt_we, act_re, wgt_re, buf_rd;
    logic [BUF_AW-1:0] act_raddr, wgt_raddr;
    logic [DATA_W-1:0] act_rdata, wgt_rdata;

    assign act_we = in_accept && (in_op == OP_WRITE) && !is_reg_addr && act_hit;
    assign wgt_we = in_accept && (in_op == OP_WRITE) && !is_reg_addr && !act_hit && wgt_hit;
    assign buf_rd = in_accept && (in_op == OP_READ) && !is_reg_addr;
    assign act_re = (buf_rd && act_hit) || (r_state == S_MAC);
    assign wgt_re = (buf_rd && !act_hit && wgt_hit) || (r_state == S_MAC);
    assign act_raddr = (r_state == S_MAC) ? r_cnt : act_off[BUF_AW-1:0];
    assign wgt_raddr = (r_state == S_MAC) ? r_cnt : wgt_off[BUF_AW-1:0];

    i8dp_ram #(.DEPTH(BUF_WORDS), .WIDTH(DATA_W)) u_act_ram (
        .i_clk   (i_clk),
        .i_we    (act_we),
        .i_waddr (act_off[BUF_AW-1:0]),
        .i_wdata (in_wdata),
        .i_re    (act_re),
        .i_raddr (act_raddr),
        .o_rdata (act_rdata)
    );

    i8dp_ram #(.DEPTH(BUF_WORDS), .WIDTH(DATA_W)) u_wgt_ram (
        .i_clk   (i_clk),
        .i_we    (wgt_we),
        .i_waddr (wgt_off[BUF_AW-1:0]),
        .i_wdata (in_wdata),
        .i_re    (wgt_re),
        .i_raddr (wgt_raddr),
        .o_rdata (wgt_rdata)
    );

    // MAC: cleared when a command starts, fed one RAM word pair per cycle during the sweep
    t_mac_ctrl               mac_ctrl;
    logic signed [ACC_W-1:0] mac_acc;
    logic                    cmd_start;

    assign cmd_start = in_accept && (in_op == OP_WRITE) &&
                       (in_addr == ADDR_COMMAND) && r_enabled;

    assign mac_ctrl.clear    = cmd_start;
    assign mac_ctrl.en       = r_rd_vld;
    assign mac_ctrl.word_idx = r_rd_idx;

    i8dp_mac u_mac (
        .i_clk  (i_clk),
        .i_ctrl (mac_ctrl),
        .i_act  (act_rdata),
        .i_wgt  (wgt_rdata),
        .o_acc  (mac_acc)
    );

    // immediate read data for register addresses
    logic [DATA_W-1:0] reg_rdata;
    always_comb begin
        reg_rdata = '0;
        if (in_op == OP_READ) begin
            case (in_addr)
                ADDR_CONTROL: reg_rdata = DATA_W'(r_enabled);
                ADDR_STATUS:  reg_rdata = DATA_W'(r_result_valid);
                ADDR_RESULT:  reg_rdata = r_dot_result;
                default:      reg_rdata = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_enabled      <= 1'b0;
            r_result_valid <= 1'b0;
            r_dot_result   <= '0;
            r_cnt          <= '0;
            r_rd_vld       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_MAC);
            r_rd_idx <= r_cnt;
            // S_RESP refills the output slot itself
            if (i_m_axis_tready && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_resp_data <= reg_rdata;
                        r_sel_act   <= act_hit;
                        r_cnt       <= '0;
                        if (in_op == OP_WRITE && in_addr == ADDR_CONTROL) begin
                            r_enabled <= in_wdata[CTRL_ENABLE_BIT];
                            if (in_wdata[CTRL_CLEAR_BIT]) begin
                                r_result_valid <= 1'b0;
                            end
                        end
                        if (cmd_start) begin
                            r_state <= S_MAC;
                        end else if (buf_rd && (act_hit || wgt_hit)) begin
                            r_state <= S_RDBUF;
                        end else begin
                            r_state <= S_RESP;
                        end
                    end
                end
                S_RDBUF: begin
                    r_resp_data <= r_sel_act ? act_rdata : wgt_rdata;
                    r_state     <= S_RESP;
                end
                S_MAC: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == BUF_AW'(BUF_WORDS - 1)) begin
                        r_state <= S_MACEND;
                    end
                end
                S_MACEND: begin
                    // last word pair accumulates at this edge
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_dot_result   <= DATA_W'(mac_acc);
                    r_result_valid <= 1'b1;
                    r_resp_data    <= '0;
                    r_state        <= S_RESP;
                end
                S_RESP: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_resp_data;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `I8DP_ASSERT_NEXT(a_cmd_starts_sweep, i_clk, i_rst_n, cmd_start, r_state == S_MAC,
        "enabled command did not start the sweep")
    `I8DP_ASSERT_NEXT(a_fin_sets_valid, i_clk, i_rst_n, r_state == S_FIN,
        r_result_valid && (r_state == S_RESP), "dot product finish did not set result-valid")
    `I8DP_ASSERT_NEXT(a_resp_delivers, i_clk, i_rst_n, (r_state == S_RESP) && i_m_axis_tready,
        o_m_axis_tvalid && (r_state == S_IDLE), "pending response not moved to output")
    `I8DP_ASSERT_IMPLY(a_mac_only_in_sweep, i_clk, i_rst_n, r_rd_vld,
        (r_state == S_MAC) || (r_state == S_MACEND), "MAC enabled outside the sweep")
endmodule

// ----- verif/int8_dot_product_engine_checker.sv -----
// Checker for the int8 dot-product engine: watches both streams and scores every read word.
`timescale 1ns / 100ps

module int8_dot_product_engine_checker import i8dp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,      // word_addr[5:0], write_data[37:6], zero pad
    input  logic [0:0]  i_s_tuser,      // op[0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,      // read_data[31:0]
    output int          o_fail_count,
    output int          o_outstanding
);

    // Shadow copy of the engine's registers and buffers.
    logic [DATA_W-1:0] act_words [BUF_WORDS];
    logic [DATA_W-1:0] wgt_words [BUF_WORDS];
    logic              engine_on;
    logic              dot_ready;
    logic [DATA_W-1:0] dot_value;

    logic [DATA_W-1:0] read_words_due [$];
    int                accepted_cnt = 0;
    int                returned_cnt = 0;
    int                fail_cnt     = 0;

    assign o_outstanding = accepted_cnt - returned_cnt;
    assign o_fail_count  = fail_cnt;

    // Index into a buffer that starts at base, or -1 when addr falls outside it.
    function automatic int buffer_slot(input logic [ADDR_W-1:0] addr, input int base);
        if (int'(addr) >= base && int'(addr) - base < BUF_WORDS) begin
            return int'(addr) - base;
        end
        return -1;
    endfunction

    // Signed sum over all lanes, lane 0 in the low byte of each word.
    function automatic logic [DATA_W-1:0] dot_of_buffers();
        int acc;
        int w;
        int k;
        acc = 0;
        for (int lane = 0; lane < LANES; lane++) begin
            w = lane / 4;
            k = lane % 4;
            acc += int'($signed(act_words[w][8*k +: 8])) * int'($signed(wgt_words[w][8*k +: 8]));
        end
        return DATA_W'(acc);
    endfunction

    // Applies one bus access to the shadow state and returns the word it reads back.
    function automatic logic [DATA_W-1:0] bus_access_result(input logic op,
                                                            input logic [ADDR_W-1:0] addr,
                                                            input logic [DATA_W-1:0] data);
        int                act_idx;
        int                wgt_idx;
        logic [DATA_W-1:0] word;
        act_idx = buffer_slot(addr, ACT_BASE_WORD);
        wgt_idx = buffer_slot(addr, WGT_BASE_WORD);
        word    = '0;
        if (op == OP_WRITE) begin
            if (addr == ADDR_CONTROL) begin
                engine_on = data[CTRL_ENABLE_BIT];
                if (data[CTRL_CLEAR_BIT]) begin
                    dot_ready = 1'b0;
                end
            end else if (addr == ADDR_COMMAND) begin
                // data is don't-care; a command while disabled does nothing
                if (engine_on) begin
                    dot_value = dot_of_buffers();
                    dot_ready = 1'b1;
                end
            end else if (act_idx >= 0) begin
                // activation buffer wins where the ranges overlap
                act_words[act_idx] = data;
            end else if (wgt_idx >= 0) begin
                wgt_words[wgt_idx] = data;
            end
        end else begin
            if (addr == ADDR_CONTROL) begin
                word = DATA_W'(engine_on);
            end else if (addr == ADDR_STATUS) begin
                word = DATA_W'(dot_ready);
            end else if (addr == ADDR_RESULT) begin
                word = dot_value;
            end else if (act_idx >= 0) begin
                word = act_words[act_idx];
            end else if (wgt_idx >= 0) begin
                word = wgt_words[wgt_idx];
            end
        end
        return word;
    endfunction

    task automatic note_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        if (fail_cnt < 10) begin
            $display("%0t ns: mismatch on %s: expected %08h actual %08h", $time, what, want, got);
        end
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            engine_on = 1'b0;
            dot_ready = 1'b0;
            dot_value = '0;
            read_words_due.delete();
            accepted_cnt <= 0;
            returned_cnt <= 0;
        end else begin
            // Retire before queuing, so a same-edge accept never matches itself.
            if (i_m_tvalid && i_m_tready) begin
                if (read_words_due.size() == 0) begin
                    note_mismatch("read_data, nothing pending", 'x, i_m_tdata);
                end else begin
                    returned_cnt <= returned_cnt + 1;
                    if (i_m_tdata !== read_words_due[0]) begin
                        note_mismatch("read_data", read_words_due[0], i_m_tdata);
                    end
                    void'(read_words_due.pop_front());
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                accepted_cnt <= accepted_cnt + 1;
                read_words_due.push_back(bus_access_result(i_s_tuser[0], i_s_tdata[5:0],
                                                           i_s_tdata[37:6]));
            end
        end
    end

endmodule

// ----- verif/int8_dot_product_engine_tb.sv -----
// Testbench top for the int8 dot-product engine: clock, reset, bus stimulus and verdict.
`timescale 1ns / 100ps

module int8_dot_product_engine_tb import i8dp_pkg::*;;

    localparam int TOTAL_ITEMS = 1900;
    localparam int QUIET_TAIL  = 150;   // last accesses run with no idling
    localparam int HOLD_CYCLES = 80;    // long receiver hold-off

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;        // word_addr[5:0], write_data[37:6], zero pad
    logic [0:0]  s_tuser  = '0;        // op[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;               // read_data[31:0]

    int fail_count;
    int outstanding;
    int sent        = 0;
    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;
    bit rx_long_hold = 1'b0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    int8_dot_product_engine dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    int8_dot_product_engine_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Offers one access, with an optional idle burst first; returns at the accepting edge.
    task automatic issue_access(input logic op, input logic [ADDR_W-1:0] addr,
                                input logic [DATA_W-1:0] data);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, data, addr};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent++;
    endtask

    // Drops valid and waits until every read word has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // Packed int8 lanes, biased toward the extremes.
    function automatic logic [DATA_W-1:0] pick_lane_word();
        logic [DATA_W-1:0] w;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 5))
                0: w[8*k +: 8] = 8'h80;
                1: w[8*k +: 8] = 8'h7F;
                2: w[8*k +: 8] = 8'hFF;
                default: w[8*k +: 8] = 8'($urandom);
            endcase
        end
        return w;
    endfunction

    // Typical driver flow: load some buffer words, enable, start, poll, fetch.
    task automatic compute_round();
        logic [DATA_W-1:0] ctrl;
        repeat ($urandom_range(0, 2 * BUF_WORDS)) begin
            if ($urandom_range(0, 1)) begin
                issue_access(OP_WRITE, ADDR_W'(ACT_BASE_WORD + $urandom_range(0, BUF_WORDS - 1)),
                             pick_lane_word());
            end else begin
                issue_access(OP_WRITE, ADDR_W'(WGT_BASE_WORD + $urandom_range(0, BUF_WORDS - 1)),
                             pick_lane_word());
            end
        end
        ctrl = $urandom;
        ctrl[CTRL_ENABLE_BIT] = ($urandom_range(0, 9) != 0);
        issue_access(OP_WRITE, ADDR_CONTROL, ctrl);
        issue_access(OP_WRITE, ADDR_COMMAND, $urandom);
        issue_access(OP_READ, ADDR_STATUS, $urandom);
        issue_access(OP_READ, ADDR_RESULT, $urandom);
        if ($urandom_range(0, 2) == 0) begin
            issue_access(OP_READ, ADDR_W'(($urandom_range(0, 1) ? ACT_BASE_WORD : WGT_BASE_WORD)
                                          + $urandom_range(0, BUF_WORDS - 1)), $urandom);
        end
    endtask

    // Sink side: random stall bursts, plus one long hold-off on request.
    initial begin
        bit hold_taken;
        hold_taken = 1'b0;
        forever begin
            @(posedge clk);
            if (rx_long_hold && !hold_taken) begin
                hold_taken = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        bit hold_done;
        bit pause_done;
        int pick;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset values, command while disabled, full-scale products,
        // ignored writes, unmapped space, clear and disable.
        issue_access(OP_READ,  ADDR_CONTROL, '0);
        issue_access(OP_READ,  ADDR_STATUS,  '0);
        issue_access(OP_READ,  ADDR_RESULT,  '0);
        issue_access(OP_READ,  ADDR_COMMAND, '1);
        issue_access(OP_WRITE, ADDR_COMMAND, '1);
        issue_access(OP_READ,  ADDR_STATUS,  '0);
        for (int i = 0; i < BUF_WORDS; i++) begin
            issue_access(OP_WRITE, ADDR_W'(ACT_BASE_WORD + i), 32'h8080_8080);
            issue_access(OP_WRITE, ADDR_W'(WGT_BASE_WORD + i), 32'h8080_8080);
        end
        issue_access(OP_WRITE, ADDR_CONTROL, 32'h0000_0001);
        issue_access(OP_READ,  ADDR_CONTROL, '0);
        issue_access(OP_WRITE, ADDR_COMMAND, '0);
        issue_access(OP_READ,  ADDR_STATUS,  '0);
        issue_access(OP_READ,  ADDR_RESULT,  '0);
        issue_access(OP_WRITE, ADDR_STATUS,  '1);
        issue_access(OP_WRITE, ADDR_RESULT,  '1);
        issue_access(OP_WRITE, ADDR_CONTROL, 32'h0000_0003);
        issue_access(OP_READ,  ADDR_STATUS,  '0);
        issue_access(OP_WRITE, ADDR_W'(ACT_BASE_WORD), 32'h7F7F_7F7F);
        issue_access(OP_WRITE, ADDR_COMMAND, '0);
        issue_access(OP_READ,  ADDR_RESULT,  '0);
        issue_access(OP_WRITE, ADDR_W'(63), '1);
        issue_access(OP_READ,  ADDR_W'(63), '1);
        issue_access(OP_READ,  ADDR_W'(ACT_BASE_WORD + BUF_WORDS), '0);
        issue_access(OP_READ,  ADDR_W'(WGT_BASE_WORD + BUF_WORDS - 1), '0);
        issue_access(OP_WRITE, ADDR_CONTROL, 32'hFFFF_FFFE);
        issue_access(OP_READ,  ADDR_CONTROL, '0);
        wait_drained();

        // Random: mostly driver-like rounds, some register pokes, some noise.
        while (sent < TOTAL_ITEMS) begin
            if (!hold_done && sent >= 700) begin
                rx_long_hold = 1'b1;
                hold_done    = 1'b1;
            end
            if (!pause_done && sent >= 1300) begin
                wait_drained();
                pause_done = 1'b1;
            end
            if (sent >= TOTAL_ITEMS - QUIET_TAIL) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                compute_round();
            end else if (pick < 80) begin
                if ($urandom_range(0, 1)) begin
                    issue_access(logic'($urandom_range(0, 1)), ADDR_W'($urandom_range(0, 3)),
                                 $urandom);
                end else begin
                    issue_access(logic'($urandom_range(0, 1)),
                                 ADDR_W'(($urandom_range(0, 1) ? ACT_BASE_WORD : WGT_BASE_WORD)
                                         + $urandom_range(0, BUF_WORDS - 1)), pick_lane_word());
                end
            end else begin
                issue_access(logic'($urandom_range(0, 1)), ADDR_W'($urandom_range(0, 63)),
                             $urandom);
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
